// ----- rtl/crpr_pkg.sv -----
// Shared constants for the CRC-protected ring record store.
// Field widths, operation and status codes, CRC polynomial, parameter defaults.
// No dependencies.
package crpr_pkg;

   localparam int SLOTS_DEFAULT       = 64;
   localparam int BLOCK_BYTES_DEFAULT = 32;

   localparam int OP_W     = 2;
   localparam int BYTE_W   = 8;
   localparam int SLOT_W   = 6;
   localparam int STATUS_W = 3;
   localparam int CRC_W    = 16;

   localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   localparam logic [STATUS_W-1:0] ST_COMMITTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_READ_BYTE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_MISMATCH  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd4;

endpackage

// ----- rtl/crpr_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module crpr_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/crpr_crc_unit.sv -----
// CRC-16/XMODEM byte step: folds one byte into a running CRC, MSB first.
// Depends on crpr_pkg.
module crpr_crc_unit (
   input  logic [crpr_pkg::CRC_W-1:0]  crc_in,
   input  logic [crpr_pkg::BYTE_W-1:0] data_in,
   output logic [crpr_pkg::CRC_W-1:0]  crc_out
);
   import crpr_pkg::*;

   always_comb begin
      logic [CRC_W-1:0] c;
      c = crc_in ^ {data_in, {(CRC_W-BYTE_W){1'b0}}};
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      crc_out = c;
   end

endmodule

// ----- rtl/crc_protected_ring_record_store_core.sv -----
// Ring record store with CRC-16/XMODEM: sequencer around one shared CRC byte unit.
// Depends on crpr_pkg, crpr_ram, crpr_crc_unit.
// Write: a non-final byte only updates staging and its CRC; a block-ending write
// copies staging to the store (S_COPY, S_COPY_END, one byte a cycle), then commits.
// Read: CRC walk over the record, then one byte a cycle on a match; busy throughout.
// Reset (sync, active high) and clear sweep the whole slot table; no stall.
module crc_protected_ring_record_store_core #(
   parameter int SLOTS       = crpr_pkg::SLOTS_DEFAULT,
   parameter int BLOCK_BYTES = crpr_pkg::BLOCK_BYTES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // command side
   input  logic                          start,
   output logic                          busy,
   input  logic [crpr_pkg::OP_W-1:0]     req_operation,
   input  logic [crpr_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic [crpr_pkg::SLOT_W-1:0]   req_slot,
   // result side
   output logic                          rsp_valid,
   output logic [crpr_pkg::STATUS_W-1:0] rsp_status,
   output logic [crpr_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic [crpr_pkg::SLOT_W-1:0]   rsp_result_slot,
   output logic [crpr_pkg::SLOT_W-1:0]   rsp_next_slot,
   output logic [crpr_pkg::CRC_W-1:0]    rsp_record_crc,
   output logic                          rsp_last
);
   import crpr_pkg::*;

   // widths derived from the geometry
   localparam int SW    = $clog2(SLOTS);
   localparam int IDX_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
   localparam int AW    = $clog2(SLOTS * BLOCK_BYTES);
   localparam int META_W = CRC_W + 1;   // {valid, crc}

   localparam logic [SW-1:0]    LAST_SLOT = SW'(SLOTS - 1);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(BLOCK_BYTES - 1);

   // sequencer states
   localparam logic [3:0] S_SWEEP    = 4'd0;  // slot table clearing pass
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_COPY     = 4'd2;  // staging -> record store
   localparam logic [3:0] S_COPY_END = 4'd3;  // last copy write, commit metadata
   localparam logic [3:0] S_RD_CHK   = 4'd4;  // slot metadata arrives
   localparam logic [3:0] S_RD_CRC   = 4'd5;  // walk record through CRC unit
   localparam logic [3:0] S_RD_CMP   = 4'd6;  // last byte folded, compare
   localparam logic [3:0] S_RD_OUT   = 4'd7;  // stream record bytes
   localparam logic [3:0] S_RD_END   = 4'd8;  // final byte out

   logic [3:0]        state_ff, state_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;           // walk issue index
   logic              pend_ff, pend_in;         // RAM read data due this cycle
   logic [IDX_W-1:0]  pend_idx_ff, pend_idx_in; // index of that data
   logic [SW-1:0]     wp_ff, wp_in;             // write pointer
   logic [IDX_W-1:0]  fill_ff, fill_in;         // bytes in staging
   logic [CRC_W-1:0]  run_crc_ff, run_crc_in;   // CRC of staging
   logic [CRC_W-1:0]  chk_crc_ff, chk_crc_in;   // CRC being rebuilt on read
   logic [CRC_W-1:0]  stored_crc_ff, stored_crc_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;         // slot of current item
   logic [AW-1:0]     base_ff, base_in;         // record base address
   logic [SW-1:0]     sweep_ff, sweep_in;
   logic              clr_ff, clr_in;           // sweep came from a clear item

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [BYTE_W-1:0]   rsp_byte_ff, rsp_byte_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [SLOT_W-1:0]   rsp_next_ff, rsp_next_in;
   logic [CRC_W-1:0]    rsp_crc_ff, rsp_crc_in;
   logic                rsp_last_ff, rsp_last_in;

   // memory ports
   logic              stg_we;
   logic [IDX_W-1:0]  stg_waddr, stg_raddr;
   logic [BYTE_W-1:0] stg_rdata;
   logic              rec_we;
   logic [AW-1:0]     rec_waddr, rec_raddr;
   logic [BYTE_W-1:0] rec_rdata;
   logic              meta_we;
   logic [SW-1:0]     meta_waddr, meta_raddr;
   logic [META_W-1:0] meta_wdata, meta_rdata;

   // shared CRC unit
   logic [CRC_W-1:0]  crc_a, crc_y;
   logic [BYTE_W-1:0] crc_b;

   logic              accept;
   logic [SW-1:0]     wp_next;
   logic [SW-1:0]     req_slot_idx;

   assign accept       = start && (state_ff == S_IDLE);
   assign busy         = (state_ff != S_IDLE);
   assign wp_next      = (wp_ff == LAST_SLOT) ? '0 : wp_ff + SW'(1);
   assign req_slot_idx = SW'(req_slot);

   // CRC unit serves staging during writes and the check walk during reads
   assign crc_a = (state_ff == S_IDLE) ? run_crc_ff : chk_crc_ff;
   assign crc_b = (state_ff == S_IDLE) ? req_data_byte : rec_rdata;

   crpr_crc_unit u_crc (
      .crc_in  (crc_a),
      .data_in (crc_b),
      .crc_out (crc_y)
   );

   crpr_ram #(.WIDTH(BYTE_W), .DEPTH(BLOCK_BYTES)) u_staging (
      .clock   (clock),
      .wr_en   (stg_we),
      .wr_addr (stg_waddr),
      .wr_data (req_data_byte),
      .rd_addr (stg_raddr),
      .rd_data (stg_rdata)
   );

   crpr_ram #(.WIDTH(BYTE_W), .DEPTH(SLOTS * BLOCK_BYTES)) u_records (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (rec_waddr),
      .wr_data (stg_rdata),
      .rd_addr (rec_raddr),
      .rd_data (rec_rdata)
   );

   crpr_ram #(.WIDTH(META_W), .DEPTH(SLOTS)) u_meta (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_waddr),
      .wr_data (meta_wdata),
      .rd_addr (meta_raddr),
      .rd_data (meta_rdata)
   );

   // fixed address paths
   assign stg_waddr  = fill_ff;
   assign stg_raddr  = cnt_ff;
   assign rec_raddr  = base_ff + AW'(cnt_ff);
   assign rec_waddr  = base_ff + AW'(pend_idx_ff);
   assign meta_raddr = req_slot_idx;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      pend_in       = 1'b0;
      pend_idx_in   = cnt_ff;
      wp_in         = wp_ff;
      fill_in       = fill_ff;
      run_crc_in    = run_crc_ff;
      chk_crc_in    = chk_crc_ff;
      stored_crc_in = stored_crc_ff;
      slot_in       = slot_ff;
      base_in       = base_ff;
      sweep_in      = sweep_ff;
      clr_in        = clr_ff;

      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_byte_in   = '0;
      rsp_slot_in   = slot_ff;
      rsp_next_in   = SLOT_W'(wp_ff);
      rsp_crc_in    = '0;
      rsp_last_in   = 1'b1;

      stg_we     = 1'b0;
      rec_we     = 1'b0;
      meta_we    = 1'b0;
      meta_waddr = wp_ff;
      meta_wdata = {1'b1, run_crc_ff};

      case (state_ff)
         S_SWEEP: begin
            meta_we    = 1'b1;
            meta_waddr = sweep_ff;
            meta_wdata = '0;
            sweep_in   = sweep_ff + SW'(1);
            if (sweep_ff == LAST_SLOT) begin
               state_in = S_IDLE;
               clr_in   = 1'b0;
               if (clr_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_CLEARED;
                  rsp_slot_in   = '0;
                  rsp_next_in   = '0;
               end
            end
         end

         S_IDLE: begin
            if (accept) begin
               case (req_operation)
                  OP_WRITE: begin
                     stg_we     = 1'b1;
                     run_crc_in = crc_y;
                     if (fill_ff == LAST_IDX) begin
                        // block complete: copy it out to the slot
                        state_in = S_COPY;
                        cnt_in   = '0;
                        base_in  = AW'(wp_ff) * AW'(BLOCK_BYTES);
                     end else begin
                        fill_in = fill_ff + IDX_W'(1);
                     end
                  end
                  OP_READ: begin
                     slot_in = req_slot;
                     if (int'(req_slot) >= SLOTS) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_EMPTY;
                        rsp_slot_in   = req_slot;
                     end else begin
                        state_in = S_RD_CHK;
                        base_in  = AW'(req_slot_idx) * AW'(BLOCK_BYTES);
                     end
                  end
                  OP_CLEAR: begin
                     wp_in      = '0;
                     fill_in    = '0;
                     run_crc_in = '0;
                     sweep_in   = '0;
                     clr_in     = 1'b1;
                     state_in   = S_SWEEP;
                  end
                  default: begin
                     // unused code: no effect
                  end
               endcase
            end
         end

         S_COPY: begin
            rec_we  = pend_ff;
            pend_in = 1'b1;
            cnt_in  = cnt_ff + IDX_W'(1);
            if (cnt_ff == LAST_IDX) begin
               state_in = S_COPY_END;
               cnt_in   = '0;
            end
         end

         S_COPY_END: begin
            rec_we        = 1'b1;
            meta_we       = 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_COMMITTED;
            rsp_slot_in   = SLOT_W'(wp_ff);
            rsp_next_in   = SLOT_W'(wp_next);
            rsp_crc_in    = run_crc_ff;
            wp_in         = wp_next;
            fill_in       = '0;
            run_crc_in    = '0;
            state_in      = S_IDLE;
         end

         S_RD_CHK: begin
            if (!meta_rdata[META_W-1]) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_EMPTY;
               state_in      = S_IDLE;
            end else begin
               stored_crc_in = meta_rdata[CRC_W-1:0];
               chk_crc_in    = '0;
               cnt_in        = '0;
               state_in      = S_RD_CRC;
            end
         end

         S_RD_CRC: begin
            if (pend_ff) begin
               chk_crc_in = crc_y;
            end
            pend_in = 1'b1;
            cnt_in  = cnt_ff + IDX_W'(1);
            if (cnt_ff == LAST_IDX) begin
               state_in = S_RD_CMP;
               cnt_in   = '0;
            end
         end

         S_RD_CMP: begin
            // crc_y now covers the whole record
            if (crc_y != stored_crc_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_MISMATCH;
               rsp_crc_in    = crc_y;
               state_in      = S_IDLE;
            end else begin
               cnt_in   = '0;
               state_in = S_RD_OUT;
            end
         end

         S_RD_OUT, S_RD_END: begin
            if (pend_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_READ_BYTE;
               rsp_byte_in   = rec_rdata;
               rsp_crc_in    = stored_crc_ff;
               rsp_last_in   = (pend_idx_ff == LAST_IDX);
            end
            if (state_ff == S_RD_OUT) begin
               pend_in = 1'b1;
               cnt_in  = cnt_ff + IDX_W'(1);
               if (cnt_ff == LAST_IDX) begin
                  state_in = S_RD_END;
                  cnt_in   = '0;
               end
            end else begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         run_crc_ff   <= '0;
         sweep_ff     <= '0;
         clr_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         run_crc_ff   <= run_crc_in;
         sweep_ff     <= sweep_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_idx_ff   <= pend_idx_in;
      chk_crc_ff    <= chk_crc_in;
      stored_crc_ff <= stored_crc_in;
      slot_ff       <= slot_in;
      base_ff       <= base_in;
      rsp_status_ff <= rsp_status_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_next_ff   <= rsp_next_in;
      rsp_crc_ff    <= rsp_crc_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_result_slot = rsp_slot_ff;
   assign rsp_next_slot   = rsp_next_ff;
   assign rsp_record_crc  = rsp_crc_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for crc_protected_ring_record_store_core: directed table, then random
// record writes, read-backs and clears, checked against table rows or an in-bench predictor.
// Depends on crpr_pkg and the core; nothing else.
module testbench;
   import crpr_pkg::*;

   localparam int SLOTS        = SLOTS_DEFAULT;
   localparam int BLOCK_BYTES  = BLOCK_BYTES_DEFAULT;
   localparam int RANDOM_ITEMS = 295;
   localparam int IDLE_LIMIT   = 1000;            // cycles with neither an item nor a result
   localparam int TAIL_CYCLES  = 2 * BLOCK_BYTES + 16;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;  // decoded as nothing by the core

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   out_byte;
      logic [SLOT_W-1:0]   result_slot;
      logic [SLOT_W-1:0]   next_slot;
      logic [CRC_W-1:0]    record_crc;
      logic                last;
   } record_result_type;

   // one row of the directed table; typed rows carry their own expectation
   typedef struct {
      logic [OP_W-1:0]   op;
      logic [BYTE_W-1:0] data;
      logic [SLOT_W-1:0] slot;
      bit                typed;
      int                n_typed;
      record_result_type res;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [OP_W-1:0]     req_operation = OP_UNUSED;
   logic [BYTE_W-1:0]   req_data_byte = '0;
   logic [SLOT_W-1:0]   req_slot = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic [SLOT_W-1:0]   rsp_result_slot;
   logic [SLOT_W-1:0]   rsp_next_slot;
   logic [CRC_W-1:0]    rsp_record_crc;
   logic                rsp_last;

   crc_protected_ring_record_store_core DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_data_byte   (req_data_byte),
      .req_slot        (req_slot),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_result_slot (rsp_result_slot),
      .rsp_next_slot   (rsp_next_slot),
      .rsp_record_crc  (rsp_record_crc),
      .rsp_last        (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // Predictor state: a copy of the ring, its checksums and valid bits, plus staging.
   // ---------------------------------------------------------------------------------
   logic [BYTE_W-1:0] ring_bytes [SLOTS][BLOCK_BYTES];
   logic [CRC_W-1:0]  ring_crc   [SLOTS];
   bit                ring_valid [SLOTS];
   logic [BYTE_W-1:0] staged_bytes [BLOCK_BYTES];
   int                staged_count = 0;
   logic [CRC_W-1:0]  staged_crc = '0;
   int                write_slot = 0;

   record_result_type expected_results [$];   // oldest first
   record_result_type predicted_now [$];      // results of the item just accepted
   stim_row_type      stim_rows [$];

   int items_sent = 0, results_checked = 0, mismatch_count = 0;
   int records_committed = 0, records_read = 0, clears_done = 0;
   int steady_left = 0, idle_cycles = 0;

   // CRC-16/XMODEM over one byte, MSB first, no reflection
   function automatic logic [CRC_W-1:0] crc16_xmodem_step(logic [CRC_W-1:0] crc,
                                                          logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++)
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      return c;
   endfunction

   function automatic record_result_type pack_result(logic [STATUS_W-1:0] st,
                                                     logic [BYTE_W-1:0] b,
                                                     logic [SLOT_W-1:0] rs,
                                                     logic [SLOT_W-1:0] ns,
                                                     logic [CRC_W-1:0] crc, logic lst);
      record_result_type r;
      r.status = st; r.out_byte = b; r.result_slot = rs;
      r.next_slot = ns; r.record_crc = crc; r.last = lst;
      return r;
   endfunction

   // Apply one accepted item to the predictor state and leave its results in predicted_now.
   function automatic void predict_store_op(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data,
                                            logic [SLOT_W-1:0] slot);
      logic [CRC_W-1:0] walk;
      int dst;
      predicted_now.delete();
      case (op)
         OP_WRITE: begin
            staged_bytes[staged_count] = data;
            staged_crc = crc16_xmodem_step(staged_crc, data);
            staged_count++;
            if (staged_count == BLOCK_BYTES) begin
               dst = write_slot;
               for (int i = 0; i < BLOCK_BYTES; i++)
                  ring_bytes[dst][i] = staged_bytes[i];
               ring_crc[dst] = staged_crc;
               ring_valid[dst] = 1'b1;
               write_slot = (dst + 1) % SLOTS;
               predicted_now.push_back(pack_result(ST_COMMITTED, '0, SLOT_W'(dst),
                                                   SLOT_W'(write_slot), staged_crc, 1'b1));
               staged_count = 0;
               staged_crc = '0;
               records_committed++;
            end
         end
         OP_READ: begin
            if (int'(slot) >= SLOTS || !ring_valid[slot]) begin
               predicted_now.push_back(pack_result(ST_EMPTY, '0, slot,
                                                   SLOT_W'(write_slot), '0, 1'b1));
            end else begin
               walk = '0;
               for (int i = 0; i < BLOCK_BYTES; i++)
                  walk = crc16_xmodem_step(walk, ring_bytes[slot][i]);
               if (walk != ring_crc[slot]) begin
                  predicted_now.push_back(pack_result(ST_MISMATCH, '0, slot,
                                                      SLOT_W'(write_slot), walk, 1'b1));
               end else begin
                  for (int i = 0; i < BLOCK_BYTES; i++)
                     predicted_now.push_back(pack_result(ST_READ_BYTE, ring_bytes[slot][i],
                                                         slot, SLOT_W'(write_slot),
                                                         ring_crc[slot],
                                                         i == BLOCK_BYTES - 1));
                  records_read++;
               end
            end
         end
         OP_CLEAR: begin
            for (int s = 0; s < SLOTS; s++)
               ring_valid[s] = 1'b0;
            write_slot = 0;
            staged_count = 0;
            staged_crc = '0;
            predicted_now.push_back(pack_result(ST_CLEARED, '0, '0, '0, '0, 1'b1));
            clears_done++;
         end
         default: ;   // unused code: no result, nothing changes
      endcase
   endfunction

   // mostly back-to-back or short gaps, now and then a long one, with idle-free stretches
   function automatic int pick_gap();
      int r;
      if (steady_left > 0) begin
         steady_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
         steady_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 82) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [BYTE_W-1:0] pick_byte();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   // Drive one item, hold it until accepted, then record what it should produce.
   task automatic issue_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                             input logic [SLOT_W-1:0] slot, input bit typed,
                             input int n_typed, input record_result_type typed_res);
      int gap;
      req_operation <= op;
      req_data_byte <= data;
      req_slot      <= slot;
      start         <= 1'b1;
      do @(posedge clock); while (busy);
      predict_store_op(op, data, slot);
      if (typed) begin
         if (n_typed > 0) expected_results.push_back(typed_res);
      end else begin
         foreach (predicted_now[i]) expected_results.push_back(predicted_now[i]);
      end
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic issue_random(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                               input logic [SLOT_W-1:0] slot);
      issue_item(op, data, slot, 1'b0, 0, '0);
   endtask

   task automatic report_field(input string name, input longint want, input longint got);
      $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------------------
   // Result checker: every strobe is matched against the oldest expectation.
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      record_result_type seen, want;
      if (!reset && rsp_valid) begin
         seen = pack_result(rsp_status, rsp_out_byte, rsp_result_slot, rsp_next_slot,
                            rsp_record_crc, rsp_last);
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status %0d slot %0d",
                     $time, seen.status, seen.result_slot);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            results_checked++;
            if (seen.status !== want.status)
               report_field("status", want.status, seen.status);
            if (seen.out_byte !== want.out_byte)
               report_field("out_byte", want.out_byte, seen.out_byte);
            if (seen.result_slot !== want.result_slot)
               report_field("result_slot", want.result_slot, seen.result_slot);
            if (seen.next_slot !== want.next_slot)
               report_field("next_slot", want.next_slot, seen.next_slot);
            if (seen.record_crc !== want.record_crc)
               report_field("record_crc", want.record_crc, seen.record_crc);
            if (seen.last !== want.last)
               report_field("last", want.last, seen.last);
         end
      end
   end

   // watchdog: a long spell with no item taken and no result means the core has hung
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d results outstanding",
                  $time, IDLE_LIMIT, expected_results.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------
   initial begin
      int random_items, r, n;
      logic [SLOT_W-1:0] pick;

      // Directed table. Fresh from reset every slot is empty and the pointer is 0, so
      // reads, clears and the unused code have results known without the predictor.
      stim_rows.push_back('{OP_READ,   8'h00, 6'd0,  1'b1, 1,
                            pack_result(ST_EMPTY, '0, 6'd0, '0, '0, 1'b1)});
      stim_rows.push_back('{OP_READ,   8'hFF, 6'd63, 1'b1, 1,
                            pack_result(ST_EMPTY, '0, 6'd63, '0, '0, 1'b1)});
      stim_rows.push_back('{OP_READ,   8'h00, 6'd42, 1'b1, 1,
                            pack_result(ST_EMPTY, '0, 6'd42, '0, '0, 1'b1)});
      stim_rows.push_back('{OP_READ,   8'h00, 6'd21, 1'b1, 1,
                            pack_result(ST_EMPTY, '0, 6'd21, '0, '0, 1'b1)});
      stim_rows.push_back('{OP_UNUSED, 8'hFF, 6'd63, 1'b1, 0, '0});
      stim_rows.push_back('{OP_CLEAR,  8'h00, 6'd63, 1'b1, 1,
                            pack_result(ST_CLEARED, '0, '0, '0, '0, 1'b1)});
      // partial block at the byte extremes, then thrown away by a clear
      stim_rows.push_back('{OP_WRITE,  8'h00, 6'd0,  1'b0, 0, '0});
      stim_rows.push_back('{OP_WRITE,  8'hFF, 6'd63, 1'b0, 0, '0});
      stim_rows.push_back('{OP_WRITE,  8'h80, 6'd0,  1'b0, 0, '0});
      stim_rows.push_back('{OP_WRITE,  8'h01, 6'd0,  1'b0, 0, '0});
      stim_rows.push_back('{OP_CLEAR,  8'hFF, 6'd0,  1'b1, 1,
                            pack_result(ST_CLEARED, '0, '0, '0, '0, 1'b1)});
      stim_rows.push_back('{OP_READ,   8'h00, 6'd0,  1'b1, 1,
                            pack_result(ST_EMPTY, '0, 6'd0, '0, '0, 1'b1)});
      stim_rows.push_back('{OP_UNUSED, 8'h00, 6'd0,  1'b1, 0, '0});
      // left staged on purpose: the first random block commits off the byte boundary
      stim_rows.push_back('{OP_WRITE,  8'h55, 6'd0,  1'b0, 0, '0});
      stim_rows.push_back('{OP_WRITE,  8'hAA, 6'd0,  1'b0, 0, '0});

      repeat (11) @(posedge clock);
      reset <= 1'b0;   // core runs its slot-table pass next, busy covers it

      foreach (stim_rows[i])
         issue_item(stim_rows[i].op, stim_rows[i].data, stim_rows[i].slot,
                    stim_rows[i].typed, stim_rows[i].n_typed, stim_rows[i].res);

      // Random part: mostly whole records and read-backs of stored slots, with partial
      // writes, empty-slot reads, rare clears and some unused-code noise.
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 22) begin
            n = BLOCK_BYTES - staged_count;   // finish the record being staged
            repeat (n) issue_random(OP_WRITE, pick_byte(), 6'($urandom_range(0, 63)));
            random_items += n;
         end else if (r < 77) begin
            if (write_slot > 0 && $urandom_range(0, 3) != 0)
               pick = SLOT_W'($urandom_range(0, write_slot - 1));
            else
               pick = SLOT_W'($urandom_range(0, 63));
            issue_random(OP_READ, pick_byte(), pick);
            random_items++;
         end else if (r < 87) begin
            n = $urandom_range(1, BLOCK_BYTES - 1);
            repeat (n) issue_random(OP_WRITE, pick_byte(), 6'($urandom_range(0, 63)));
            random_items += n;
         end else if (r < 90) begin
            issue_random(OP_CLEAR, pick_byte(), 6'($urandom_range(0, 63)));
            random_items++;
         end else begin
            issue_random(OP_UNUSED, pick_byte(), 6'($urandom_range(0, 63)));
         end
      end
      start <= 1'b0;

      // drain, then give the core time to show any stray result
      while (expected_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d items and %0d checked results:", items_sent, results_checked);
      $display("  %0d records committed, %0d records read back, %0d clears",
               records_committed, records_read, clears_done);
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
